FILE: rtl/periodic_priority_task_scheduler_macros.svh
// Assertion macros used by the scheduler controller.
`ifndef PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define PPTS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define PPTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ppts_pkg.sv
//------------------------------------------------------------------------------
// ppts_pkg
// Shared types, codes and sizes of the periodic priority task scheduler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        CMD_SCHEDULE = 4'd0,
        CMD_ADD      = 4'd1,
        CMD_DELAY    = 4'd2,
        CMD_REMOVE   = 4'd3,
        CMD_PROMOTE  = 4'd4,
        CMD_LOCK     = 4'd5,
        CMD_UNLOCK   = 4'd6,
        CMD_SETRUN   = 4'd7,
        CMD_CLEAR    = 4'd8
    } cmd_t;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] now_ms;
        logic [3:0]  task_index;
        logic [31:0] period_ms;
        logic [31:0] delay_ms;
        logic [7:0]  priority_value;
        logic        flag_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0] chosen_task;
        logic       task_chosen;
        logic       run_ok;
        logic       accepted;
        logic [4:0] tasks_in_use;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SHIFT,
        S_CLEAR,
        S_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture input item, pointer to zero (to the index for a remove)
        logic scan_step; // evaluate entry at pointer, advance
        logic apply;     // single-entry update
        logic shift_step;// move entry pointer+1 down to pointer
        logic clr_step;  // zero entry at pointer
        logic finish;    // marks the last scan or clear step
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [3:0] cmd;
        logic       valid;
        logic       scan_last;
        logic       shift_last;
        logic       clr_last;
    } sts_t;

endpackage

FILE: rtl/ppts_stream_if.sv
//------------------------------------------------------------------------------
// ppts_stream_if
// Valid/ready channel carrying one item of a given payload type.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ppts_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/periodic_priority_task_scheduler.sv
//------------------------------------------------------------------------------
// periodic_priority_task_scheduler
// Top level: task table with schedule, add, delay, remove, priority, run-flag and clear commands.
//------------------------------------------------------------------------------
// Each command takes one item and returns one result, which is held until it
// is taken. Single-entry commands pass from idle through apply to the result;
// schedule and lock step once per held task, and at least once; remove shifts
// the entries above the index one per cycle and then zeroes the vacated slot;
// clear zeroes all MAX_TASKS slots, one per cycle. The one-entry-per-cycle
// table walk sets the rate. One item is in flight at a time.
`timescale 1ns / 1ps
module periodic_priority_task_scheduler (
    input logic clk,
    input logic rst_n,
    ppts_stream_if.sink   in_ch,
    ppts_stream_if.source out_ch
);
    import ppts_pkg::*;

    ctl_t ctl;
    sts_t sts;

    ppts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    ppts_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch.payload),
        .ctl      (ctl),
        .sts      (sts),
        .out_item (out_ch.payload)
    );
endmodule

FILE: rtl/ppts_ctrl.sv
//------------------------------------------------------------------------------
// ppts_ctrl
// Sequencer that steps the datapath through scans, shifts and clears.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ppts_pkg::sts_t sts,
    output ppts_pkg::ctl_t ctl
);
    import ppts_pkg::*;
    `include "periodic_priority_task_scheduler_macros.svh"

    state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // For a remove the pointer already holds the index, so no entry
                // sits above it when the pointer is at the top held slot.
                priority case (1'b1)
                    (sts.cmd == CMD_SCHEDULE) || (sts.cmd == CMD_LOCK):
                        state_next = S_SCAN;
                    (sts.cmd == CMD_REMOVE) && sts.valid:
                        state_next = sts.scan_last ? S_CLEAR : S_SHIFT;
                    sts.cmd == CMD_CLEAR:
                        state_next = S_CLEAR;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                    state_next = S_OUT;
            end
            S_SHIFT:
            begin
                if (sts.shift_last)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (sts.clr_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_APPLY: ctl.apply = 1'b1;
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                ctl.finish    = sts.scan_last;
            end
            S_SHIFT: ctl.shift_step = 1'b1;
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                ctl.finish   = sts.clr_last;
            end
            S_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `PPTS_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `PPTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PPTS_ASSERT_NEXT(a_load_apply, clk, rst_n, ctl.load, state_reg == S_APPLY)
endmodule

FILE: rtl/ppts_datapath.sv
//------------------------------------------------------------------------------
// ppts_datapath
// Task table, entry pointer and scan registers of the scheduler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ppts_pkg::in_item_t  in_item,
    input  ppts_pkg::ctl_t      ctl,
    output ppts_pkg::sts_t      sts,
    output ppts_pkg::out_item_t out_item
);
    import ppts_pkg::*;

    logic [31:0]      period_reg   [MAX_TASKS];
    logic [31:0]      last_reg     [MAX_TASKS];
    logic [31:0]      unblk_reg    [MAX_TASKS];
    logic [7:0]       prio_reg     [MAX_TASKS];
    logic [8:0]       saved_reg    [MAX_TASKS];
    logic [1:0]       tstate_reg   [MAX_TASKS];
    logic [1:0]       flag_reg     [MAX_TASKS];
    logic [CNT_W-1:0] total_reg;

    in_item_t         item_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             have_reg;
    logic             done_reg;
    logic [IDX_W-1:0] best_reg;
    logic [7:0]       bestp_reg;
    logic             ok_reg;
    logic             acc_reg;
    out_item_t        res_reg;

    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] pn;
    logic             valid;
    logic [1:0]       st_eff;
    logic             elig;
    logic [CNT_W-1:0] clr_end;

    assign p     = ptr_reg[IDX_W-1:0];
    assign pn    = IDX_W'(ptr_reg + CNT_W'(1));
    assign idx   = item_reg.task_index[IDX_W-1:0];
    assign valid = ({{(CNT_W > 4 ? CNT_W - 4 : 1){1'b0}}, item_reg.task_index} < total_reg)
        && (32'(item_reg.task_index) < 32'(MAX_TASKS));
    // Clearing ends at the last slot for a clear, or the vacated top slot for a remove.
    assign clr_end = (item_reg.command == CMD_CLEAR) ? CNT_W'(MAX_TASKS - 1)
                                                    : total_reg - CNT_W'(1);

    // Wake test and eligibility of the entry under the pointer.
    always_comb
    begin
        st_eff = tstate_reg[p];
        if (st_eff == ST_BLOCKED && item_reg.now_ms >= unblk_reg[p])
            st_eff = ST_READY;
        elig = (st_eff == ST_READY) && ((item_reg.now_ms - last_reg[p]) >= period_reg[p]);
    end

    assign sts.cmd        = item_reg.command;
    assign sts.valid      = valid;
    assign sts.scan_last  = (ptr_reg + CNT_W'(1) >= total_reg);
    assign sts.shift_last = (ptr_reg + CNT_W'(1) >= total_reg - CNT_W'(1));
    assign sts.clr_last   = (ptr_reg >= clr_end);
    assign out_item       = res_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (ctl.apply && item_reg.command == CMD_ADD && total_reg < CNT_W'(MAX_TASKS))
            total_reg <= total_reg + CNT_W'(1);
        else if (ctl.apply && item_reg.command == CMD_CLEAR)
            total_reg <= '0;
        else if (ctl.clr_step && sts.clr_last && item_reg.command == CMD_REMOVE)
            total_reg <= total_reg - CNT_W'(1);
    end

    // Table reset clears every entry at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                period_reg[i] <= '0; last_reg[i] <= '0; unblk_reg[i] <= '0;
                prio_reg[i] <= '0; saved_reg[i] <= '0; tstate_reg[i] <= '0;
                flag_reg[i] <= '0;
            end
        end
        else if (ctl.apply)
        begin
            unique case (item_reg.command)
                CMD_ADD:
                begin
                    if (total_reg < CNT_W'(MAX_TASKS))
                    begin
                        period_reg[total_reg[IDX_W-1:0]] <= item_reg.period_ms;
                        last_reg[total_reg[IDX_W-1:0]]   <= '0;
                        unblk_reg[total_reg[IDX_W-1:0]]  <= '0;
                        prio_reg[total_reg[IDX_W-1:0]]   <= item_reg.priority_value;
                        saved_reg[total_reg[IDX_W-1:0]]  <= {1'b1, item_reg.priority_value};
                        tstate_reg[total_reg[IDX_W-1:0]] <= ST_READY;
                        flag_reg[total_reg[IDX_W-1:0]]   <= {1'b0, item_reg.flag_value};
                    end
                end
                CMD_DELAY:
                begin
                    if (valid)
                    begin
                        tstate_reg[idx] <= ST_BLOCKED;
                        unblk_reg[idx]  <= item_reg.now_ms + item_reg.delay_ms;
                    end
                end
                CMD_PROMOTE:
                begin
                    if (valid && item_reg.priority_value > prio_reg[idx])
                        prio_reg[idx] <= item_reg.priority_value;
                end
                CMD_UNLOCK:
                begin
                    if (valid && saved_reg[idx][8])
                    begin
                        prio_reg[idx]  <= saved_reg[idx][7:0];
                        saved_reg[idx] <= '0;
                    end
                end
                CMD_SETRUN:
                begin
                    if (valid)
                        flag_reg[idx][1] <= item_reg.flag_value;
                end
                default: ;
            endcase
        end
        else if (ctl.scan_step && item_reg.command == CMD_SCHEDULE)
        begin
            logic             w;
            logic [IDX_W-1:0] b;
            // Winner so far, including the entry under the pointer.
            w = have_reg;
            b = best_reg;
            if (ptr_reg < total_reg && elig && (!have_reg || prio_reg[p] > bestp_reg))
            begin
                w = 1'b1;
                b = p;
            end
            // Write back the wake result unless this entry is the winner run now.
            if (ptr_reg < total_reg && !(sts.scan_last && w && b == p))
                tstate_reg[p] <= st_eff;
            // On the last entry run the winner.
            if (sts.scan_last && w)
            begin
                if (flag_reg[b][0])
                begin
                    last_reg[b]   <= item_reg.now_ms;
                    tstate_reg[b] <= ST_READY;
                end
                else
                    tstate_reg[b] <= ST_FAILED;
                if (saved_reg[b][8])
                begin
                    prio_reg[b]  <= saved_reg[b][7:0];
                    saved_reg[b] <= '0;
                end
            end
        end
        else if (ctl.scan_step && item_reg.command == CMD_LOCK)
        begin
            // The first higher ready task lends its priority.
            if (valid && flag_reg[idx][1] && !done_reg && ptr_reg < total_reg && p != idx
                && tstate_reg[p] == ST_READY && prio_reg[p] > prio_reg[idx])
            begin
                saved_reg[idx] <= {1'b1, prio_reg[idx]};
                prio_reg[idx]  <= prio_reg[p];
            end
        end
        else if (ctl.shift_step)
        begin
            period_reg[p] <= period_reg[pn]; last_reg[p] <= last_reg[pn];
            unblk_reg[p] <= unblk_reg[pn]; prio_reg[p] <= prio_reg[pn];
            saved_reg[p] <= saved_reg[pn]; tstate_reg[p] <= tstate_reg[pn];
            flag_reg[p] <= flag_reg[pn];
        end
        else if (ctl.clr_step && (item_reg.command == CMD_CLEAR || sts.clr_last))
        begin
            period_reg[p] <= '0; last_reg[p] <= '0; unblk_reg[p] <= '0;
            prio_reg[p] <= '0; saved_reg[p] <= '0; tstate_reg[p] <= '0;
            flag_reg[p] <= '0;
        end
    end

    // Pointer, scan tracking and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
            best_reg  <= '0;
            bestp_reg <= '0;
            ok_reg    <= 1'b0;
            acc_reg   <= 1'b0;
        end
        else if (ctl.load)
        begin
            // A remove starts its walk at the index; every other walk starts at zero.
            ptr_reg  <= (in_item.command == CMD_REMOVE) ? CNT_W'(in_item.task_index) : '0;
            have_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            acc_reg  <= 1'b0;
        end
        else if (ctl.apply)
        begin
            unique case (item_reg.command)
                CMD_ADD:   acc_reg <= (total_reg < CNT_W'(MAX_TASKS));
                CMD_CLEAR: acc_reg <= 1'b1;
                CMD_SCHEDULE: acc_reg <= 1'b0;
                CMD_DELAY, CMD_REMOVE, CMD_PROMOTE, CMD_LOCK, CMD_UNLOCK, CMD_SETRUN:
                    acc_reg <= valid;
                default: acc_reg <= 1'b0;
            endcase
            ptr_reg <= (item_reg.command == CMD_REMOVE) ? CNT_W'(idx) : '0;
        end
        else if (ctl.scan_step)
        begin
            ptr_reg <= ptr_reg + CNT_W'(1);
            if (item_reg.command == CMD_SCHEDULE && ptr_reg < total_reg && elig
                && (!have_reg || prio_reg[p] > bestp_reg))
            begin
                have_reg  <= 1'b1;
                best_reg  <= p;
                bestp_reg <= prio_reg[p];
                ok_reg    <= flag_reg[p][0];
            end
            if (item_reg.command == CMD_LOCK && ptr_reg < total_reg && p != idx
                && tstate_reg[p] == ST_READY && prio_reg[p] > prio_reg[idx])
                done_reg <= 1'b1;
        end
        else if (ctl.shift_step)
            ptr_reg <= ptr_reg + CNT_W'(1);
        else if (ctl.clr_step && !sts.clr_last)
            ptr_reg <= ptr_reg + CNT_W'(1);
    end

    // Result is registered at each apply, scan and clear step, with the table update.
    always_ff @(posedge clk)
    begin
        if (ctl.apply || ctl.scan_step || ctl.clr_step)
        begin
            logic             h;
            logic [IDX_W-1:0] b;
            logic             o;
            h = have_reg; b = best_reg; o = ok_reg;
            if (ctl.scan_step && item_reg.command == CMD_SCHEDULE && ptr_reg < total_reg
                && elig && (!have_reg || prio_reg[p] > bestp_reg))
            begin
                h = 1'b1; b = p; o = flag_reg[p][0];
            end
            res_reg.chosen_task  <= h ? 4'(b) : 4'd0;
            res_reg.task_chosen  <= h;
            res_reg.run_ok       <= h && o;
            res_reg.accepted     <= (item_reg.command == CMD_SCHEDULE) ? h :
                                    (ctl.apply ? ((item_reg.command == CMD_ADD) ?
                                    (total_reg < CNT_W'(MAX_TASKS)) :
                                    (item_reg.command == CMD_CLEAR) ? 1'b1 :
                                    (item_reg.command <= CMD_SETRUN) && valid) : acc_reg);
            res_reg.tasks_in_use <= 5'(ctl.apply ? ((item_reg.command == CMD_ADD &&
                                    total_reg < CNT_W'(MAX_TASKS)) ? total_reg + CNT_W'(1) :
                                    (item_reg.command == CMD_CLEAR) ? CNT_W'(0) : total_reg)
                                    : (ctl.clr_step && sts.clr_last &&
                                    item_reg.command == CMD_REMOVE) ?
                                    total_reg - CNT_W'(1) : total_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= in_item;
    end
endmodule

FILE: dv/tb.sv
//------------------------------------------------------------------------------
// tb
// Testbench for the periodic priority task scheduler. It predicts each result
// from its own copy of the task table and checks every field of every result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import ppts_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;

    ppts_stream_if #(.payload_t(in_item_t))  cmd_ch ();
    ppts_stream_if #(.payload_t(out_item_t)) res_ch ();

    periodic_priority_task_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch.sink),
        .out_ch (res_ch.source)
    );

    // Predicted task table.
    logic [4:0]  tbl_total;
    logic [31:0] tbl_period   [MAX_TASKS];
    logic [31:0] tbl_last_run [MAX_TASKS];
    logic [31:0] tbl_unblock  [MAX_TASKS];
    logic [7:0]  tbl_prio     [MAX_TASKS];
    logic [8:0]  tbl_saved    [MAX_TASKS];
    logic [1:0]  tbl_state    [MAX_TASKS];
    logic [1:0]  tbl_flags    [MAX_TASKS];

    in_item_t  pending_cmds[$];
    out_item_t expected_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_send;
    int unsigned error_count;
    int unsigned accepted_count;
    int unsigned result_count;
    int unsigned sched_hits;
    int unsigned idle_cycles;
    bit          stimulus_done;

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, result_count);
        error_count++;
    endtask

    function automatic void table_wipe();
        tbl_total = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            tbl_period[i]   = '0;
            tbl_last_run[i] = '0;
            tbl_unblock[i]  = '0;
            tbl_prio[i]     = '0;
            tbl_saved[i]    = '0;
            tbl_state[i]    = ST_READY;
            tbl_flags[i]    = '0;
        end
    endfunction

    function automatic void restore_priority(input int t);
        if (tbl_saved[t][8])
        begin
            tbl_prio[t]  = tbl_saved[t][7:0];
            tbl_saved[t] = '0;
        end
    endfunction

    // Works out the result of one command and updates the predicted table.
    function automatic out_item_t predict_schedule_result(input in_item_t c);
        out_item_t r;
        bit        have;
        int        best;
        int        idx;
        bit        ok_idx;
        r = '0;
        have = 1'b0;
        best = 0;
        idx = c.task_index;
        ok_idx = idx < tbl_total;
        case (c.command)
            CMD_SCHEDULE:
            begin
                for (int i = 0; i < tbl_total; i++)
                begin
                    if (tbl_state[i] == ST_BLOCKED && c.now_ms >= tbl_unblock[i])
                        tbl_state[i] = ST_READY;
                    if (tbl_state[i] == ST_READY &&
                        (c.now_ms - tbl_last_run[i]) >= tbl_period[i])
                    begin
                        if (!have || tbl_prio[i] > tbl_prio[best])
                        begin
                            have = 1'b1;
                            best = i;
                        end
                    end
                end
                if (have)
                begin
                    r.task_chosen = 1'b1;
                    r.chosen_task = best[3:0];
                    if (tbl_flags[best][0])
                    begin
                        r.run_ok = 1'b1;
                        tbl_last_run[best] = c.now_ms;
                        tbl_state[best] = ST_READY;
                    end
                    else
                        tbl_state[best] = ST_FAILED;
                    restore_priority(best);
                end
                r.accepted = have;
            end
            CMD_ADD:
            begin
                if (tbl_total < MAX_TASKS)
                begin
                    tbl_period[tbl_total]   = c.period_ms;
                    tbl_last_run[tbl_total] = '0;
                    tbl_unblock[tbl_total]  = '0;
                    tbl_prio[tbl_total]     = c.priority_value;
                    tbl_saved[tbl_total]    = {1'b1, c.priority_value};
                    tbl_state[tbl_total]    = ST_READY;
                    tbl_flags[tbl_total]    = {1'b0, c.flag_value};
                    tbl_total++;
                    r.accepted = 1'b1;
                end
            end
            CMD_DELAY:
            begin
                if (ok_idx)
                begin
                    tbl_state[idx]   = ST_BLOCKED;
                    tbl_unblock[idx] = c.now_ms + c.delay_ms;
                    r.accepted = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (ok_idx)
                begin
                    for (int i = idx; i + 1 < tbl_total; i++)
                    begin
                        tbl_period[i]   = tbl_period[i+1];
                        tbl_last_run[i] = tbl_last_run[i+1];
                        tbl_unblock[i]  = tbl_unblock[i+1];
                        tbl_prio[i]     = tbl_prio[i+1];
                        tbl_saved[i]    = tbl_saved[i+1];
                        tbl_state[i]    = tbl_state[i+1];
                        tbl_flags[i]    = tbl_flags[i+1];
                    end
                    tbl_total--;
                    tbl_period[tbl_total]   = '0;
                    tbl_last_run[tbl_total] = '0;
                    tbl_unblock[tbl_total]  = '0;
                    tbl_prio[tbl_total]     = '0;
                    tbl_saved[tbl_total]    = '0;
                    tbl_state[tbl_total]    = ST_READY;
                    tbl_flags[tbl_total]    = '0;
                    r.accepted = 1'b1;
                end
            end
            CMD_PROMOTE:
            begin
                if (ok_idx)
                begin
                    if (c.priority_value > tbl_prio[idx])
                        tbl_prio[idx] = c.priority_value;
                    r.accepted = 1'b1;
                end
            end
            CMD_LOCK:
            begin
                if (ok_idx)
                begin
                    if (tbl_flags[idx][1])
                    begin
                        for (int i = 0; i < tbl_total; i++)
                        begin
                            if (!have && i != idx && tbl_state[i] == ST_READY &&
                                tbl_prio[i] > tbl_prio[idx])
                            begin
                                tbl_saved[idx] = {1'b1, tbl_prio[idx]};
                                tbl_prio[idx]  = tbl_prio[i];
                                have = 1'b1;
                            end
                        end
                    end
                    r.accepted = 1'b1;
                end
            end
            CMD_UNLOCK:
            begin
                if (ok_idx)
                begin
                    restore_priority(idx);
                    r.accepted = 1'b1;
                end
            end
            CMD_SETRUN:
            begin
                if (ok_idx)
                begin
                    tbl_flags[idx][1] = c.flag_value;
                    r.accepted = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                table_wipe();
                r.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.tasks_in_use = tbl_total;
        return r;
    endfunction

    function automatic in_item_t make_cmd(input logic [3:0] op, input logic [31:0] now,
                                          input logic [3:0] idx);
        in_item_t c;
        c.command        = op;
        c.now_ms         = now;
        c.task_index     = idx;
        c.period_ms      = $urandom_range(0, 60);
        c.delay_ms       = $urandom_range(0, 40);
        c.priority_value = 8'($urandom);
        c.flag_value     = $urandom_range(0, 3) != 0;
        return c;
    endfunction

    // Random command; mostly well-formed with small times, some raw noise.
    function automatic in_item_t random_cmd(input logic [31:0] now);
        in_item_t c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c = make_cmd(CMD_SCHEDULE, now, 4'($urandom_range(0, 15)));
        if (pick < 30)
            c.command = CMD_SCHEDULE;
        else if (pick < 48)
            c.command = CMD_ADD;
        else if (pick < 56)
            c.command = CMD_DELAY;
        else if (pick < 62)
            c.command = CMD_REMOVE;
        else if (pick < 69)
            c.command = CMD_PROMOTE;
        else if (pick < 78)
            c.command = CMD_LOCK;
        else if (pick < 84)
            c.command = CMD_UNLOCK;
        else if (pick < 93)
            c.command = CMD_SETRUN;
        else if (pick < 95)
            c.command = CMD_CLEAR;
        else
        begin
            c.command = 4'($urandom_range(9, 15));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            c.now_ms     = $urandom;
            c.period_ms  = $urandom;
            c.delay_ms   = $urandom;
        end
        return c;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.payload <= '0;
        end
        else
        begin
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_ch.valid)
                begin
                    expected_results.push_back(predict_schedule_result(cmd_ch.payload));
                    accepted_count++;
                end
                if (pending_cmds.size() != 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.payload <= pending_cmds.pop_front();
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and checker; also drives the ready side.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result %0d", result_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.payload.chosen_task != want.chosen_task)
                        report_mismatch("chosen_task", res_ch.payload.chosen_task,
                                        want.chosen_task);
                    if (res_ch.payload.task_chosen != want.task_chosen)
                        report_mismatch("task_chosen", res_ch.payload.task_chosen,
                                        want.task_chosen);
                    if (res_ch.payload.run_ok != want.run_ok)
                        report_mismatch("run_ok", res_ch.payload.run_ok, want.run_ok);
                    if (res_ch.payload.accepted != want.accepted)
                        report_mismatch("accepted", res_ch.payload.accepted,
                                        want.accepted);
                    if (res_ch.payload.tasks_in_use != want.tasks_in_use)
                        report_mismatch("tasks_in_use", res_ch.payload.tasks_in_use,
                                        want.tasks_in_use);
                    if (want.task_chosen)
                        sched_hits++;
                end
                result_count++;
            end
            res_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            stimulus_done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [31:0] clock_ms;
        int          drained;
        table_wipe();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        error_count = 0;
        accepted_count = 0;
        result_count = 0;
        sched_hits = 0;
        idle_cycles = 0;
        stimulus_done = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, fill past full, extremes, every command.
        pending_cmds.push_back(make_cmd(CMD_SCHEDULE, 32'd0, 4'd0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'd0, 4'd0));
        for (int i = 0; i < 17; i++)
        begin
            in_item_t c;
            c = make_cmd(CMD_ADD, 32'd0, 4'd0);
            c.priority_value = (i == 3) ? 8'hFF : i[7:0];
            c.period_ms = (i == 5) ? 32'hFFFF_FFFF : i;
            c.flag_value = i != 2;
            pending_cmds.push_back(c);
        end
        begin
            in_item_t c;
            c = make_cmd(CMD_DELAY, 32'hFFFF_FFF0, 4'd15);
            c.delay_ms = 32'hFFFF_FFFF;
            pending_cmds.push_back(c);
            c = make_cmd(CMD_SETRUN, 32'd0, 4'd1);
            c.flag_value = 1'b1;
            pending_cmds.push_back(c);
            pending_cmds.push_back(make_cmd(CMD_LOCK, 32'd0, 4'd1));
            pending_cmds.push_back(make_cmd(CMD_SCHEDULE, 32'hFFFF_FFFF, 4'd0));
            pending_cmds.push_back(make_cmd(CMD_UNLOCK, 32'd0, 4'd1));
            c = make_cmd(CMD_PROMOTE, 32'd0, 4'd0);
            c.priority_value = 8'hFF;
            pending_cmds.push_back(c);
            pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'd0, 4'd0));
            pending_cmds.push_back(make_cmd(CMD_CLEAR, 32'd0, 4'd0));
            pending_cmds.push_back(make_cmd(4'hF, 32'd0, 4'd0));
        end

        // Random phases with differing idle and stall rates.
        clock_ms = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            while (pending_cmds.size() != 0 || cmd_ch.valid)
                @(posedge clk);
            if (phase == 2)
            begin
                // Hold the sender off until every result is back.
                hold_send = 1'b1;
                drained = 0;
                while (expected_results.size() != 0 && drained < IDLE_LIMIT)
                begin
                    @(posedge clk);
                    drained++;
                end
                hold_send = 1'b0;
            end
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 110; n++)
            begin
                clock_ms = clock_ms + $urandom_range(0, 25);
                pending_cmds.push_back(random_cmd(clock_ms));
            end
        end

        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        stimulus_done = 1'b1;
        drained = 0;
        while (expected_results.size() != 0 && drained < IDLE_LIMIT)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (40) @(posedge clk);

        $display("%0d commands sent, %0d results checked, %0d schedules picked a task",
                 accepted_count, result_count, sched_hits);
        $display("idle and stall phases covered, table filled past full and cleared");
        if (error_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
